// ===== sv/doubly_linked_list_engine_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the list engine modules.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define DLL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define DLL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/dll_pkg.sv =====
// ---------------------------------------------------------------------------
// dll_pkg
// Types and fixed constants of the doubly linked list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dll_pkg;

    // Fixed payload widths
    localparam int DATA_BITS   = 32;
    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 2;

    // Action codes; the two unused codes are rejected
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_PREPEND = 3'd1,
        ACT_AFTER   = 3'd2,
        ACT_BEFORE  = 3'd3,
        ACT_REMOVE  = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOOK = 2'd1,
        S_LINK = 2'd2
    } fsm_t;

    // Write enables of the four node memories
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
        logic used;
    } node_we_t;

    // Allocator commands
    typedef struct packed {
        logic take;
        logic push;
    } alloc_cmd_t;

endpackage

// ===== sv/dll_ifs.sv =====
// ---------------------------------------------------------------------------
// dll_cmd_if / dll_rsp_if
// Valid/ready channels for list commands and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dll_cmd_if
    import dll_pkg::*;
#(
    parameter int HANDLE_BITS = 7
);
    logic                          valid;
    logic                          ready;
    logic [ACTION_BITS-1:0]        action;
    logic [HANDLE_BITS-1:0]        position;
    logic signed [DATA_BITS-1:0]   value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface dll_rsp_if
    import dll_pkg::*;
#(
    parameter int HANDLE_BITS = 7
);
    logic                          valid;
    logic                          ready;
    logic [STATUS_BITS-1:0]        status;
    logic [HANDLE_BITS-1:0]        handle;
    logic signed [DATA_BITS-1:0]   read_value;
    logic [HANDLE_BITS-1:0]        next_handle;
    logic [HANDLE_BITS-1:0]        prev_handle;
    logic [HANDLE_BITS-1:0]        head_handle;
    logic [HANDLE_BITS-1:0]        tail_handle;
    logic [HANDLE_BITS-1:0]        length;

    modport source (output valid, output status, output handle, output read_value,
                    output next_handle, output prev_handle, output head_handle,
                    output tail_handle, output length, input ready);
    modport sink   (input valid, input status, input handle, input read_value,
                    input next_handle, input prev_handle, input head_handle,
                    input tail_handle, input length, output ready);
endinterface

// ===== sv/doubly_linked_list_engine_top.sv =====
// ---------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Doubly linked list over a fixed node pool, with its own node allocator.
// ---------------------------------------------------------------------------
// Commands arrive on cmd and each produces one result on rsp. A command that
// adds no node (read, remove or any rejected command) goes through the idle
// and look states, an insert through idle, look and link: the accepting cycle
// reads the reference node and the free-stack top from their memories, look
// writes the new node and link patches the neighbor links, since each link
// memory has a single write port. The result is registered in look when no
// node is added and in link for an insert. The next command is accepted the
// cycle after the previous one has left the sequencer; a finished result
// waits in the output register and the sequencer stalls only if that register
// is still full. Node storage needs no clearing pass after reset: handles at
// or above the bump pointer count as unused. head_handle, tail_handle and
// length show the list state after the action of the result on rsp.
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_top_defines.svh"

module doubly_linked_list_engine_top
    import dll_pkg::*;
#(
    parameter int POOL_SIZE  = 64,
    parameter int VALUE_BITS = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    dll_cmd_if.sink   cmd,
    dll_rsp_if.source rsp
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int HW = $clog2(POOL_SIZE + 1);
    localparam logic [HW-1:0] NONE = HW'(POOL_SIZE);

    // Sequencer and list state
    fsm_t                  state_reg;
    fsm_t                  state_next;
    logic [HW-1:0]         head_reg;
    logic [HW-1:0]         head_next;
    logic [HW-1:0]         tail_reg;
    logic [HW-1:0]         tail_next;
    logic [HW-1:0]         count_reg;
    logic [HW-1:0]         count_next;

    // Captured command and link-stage operands
    action_t               act_reg;
    logic [HW-1:0]         pos_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [HW-1:0]         h_reg;
    logic [HW-1:0]         p_reg;
    logic [HW-1:0]         n_reg;

    // Output register
    logic                  ovalid_reg;
    status_t               ostat_reg;
    logic [HW-1:0]         ohandle_reg;
    logic [DATA_BITS-1:0]  ovalue_reg;
    logic [HW-1:0]         onext_reg;
    logic [HW-1:0]         oprev_reg;

    // Node memory ports
    node_we_t              we;
    logic [IW-1:0]         waddr;
    logic [IW-1:0]         next_addr;
    logic [IW-1:0]         prev_addr;
    logic [VALUE_BITS-1:0] wval;
    logic [HW-1:0]         wnext;
    logic [HW-1:0]         wprev;
    logic                  wuse;
    logic [VALUE_BITS-1:0] rd_val;
    logic [HW-1:0]         rd_next;
    logic [HW-1:0]         rd_prev;
    logic                  rd_use;

    // Allocator ports
    alloc_cmd_t            acmd;
    logic [IW-1:0]         push_handle;
    logic [HW-1:0]         alloc_handle;
    logic [HW-1:0]         fresh;

    // Decode and result signals
    logic                  accept;
    logic                  can_out;
    logic                  live;
    logic                  full;
    logic                  is_ins;
    logic                  lk_ok;
    logic [HW-1:0]         lk_p;
    logic [HW-1:0]         lk_n;
    logic                  link_load;
    logic                  fin;
    status_t               res_stat;
    logic [HW-1:0]         res_h;
    logic [VALUE_BITS-1:0] res_val;
    logic [HW-1:0]         res_n;
    logic [HW-1:0]         res_p;
    logic                  list_empty;
    logic                  out_fail;

    dll_node_mem #(
        .POOL_SIZE  (POOL_SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_nodes (
        .clk       (clk),
        .ren       (accept),
        .raddr     (cmd.position[IW-1:0]),
        .we        (we),
        .waddr     (waddr),
        .next_addr (next_addr),
        .prev_addr (prev_addr),
        .wval      (wval),
        .wnext     (wnext),
        .wprev     (wprev),
        .wuse      (wuse),
        .rd_val    (rd_val),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev),
        .rd_use    (rd_use)
    );

    dll_alloc #(
        .POOL_SIZE (POOL_SIZE)
    ) u_alloc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ren          (accept),
        .cmd          (acmd),
        .push_handle  (push_handle),
        .alloc_handle (alloc_handle),
        .fresh        (fresh)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign can_out   = !ovalid_reg || rsp.ready;
    assign live      = (pos_reg < fresh) && rd_use;
    assign full      = (alloc_handle == NONE);

    // Resolve the neighbors of a new node
    always_comb
    begin
        lk_p   = NONE;
        lk_n   = NONE;
        lk_ok  = 1'b1;
        is_ins = 1'b1;
        case (act_reg)
            ACT_APPEND:
            begin
                lk_p = tail_reg;
            end
            ACT_PREPEND:
            begin
                lk_n = head_reg;
            end
            ACT_AFTER:
            begin
                if (pos_reg == NONE)
                begin
                    lk_n = head_reg;
                end
                else if (live)
                begin
                    lk_p = pos_reg;
                    lk_n = rd_next;
                end
                else
                begin
                    lk_ok = 1'b0;
                end
            end
            ACT_BEFORE:
            begin
                if (pos_reg == NONE)
                begin
                    lk_p = tail_reg;
                end
                else if (live)
                begin
                    lk_p = rd_prev;
                    lk_n = pos_reg;
                end
                else
                begin
                    lk_ok = 1'b0;
                end
            end
            default:
            begin
                is_ins = 1'b0;
                lk_ok  = 1'b0;
            end
        endcase
    end

    // Sequence the memory updates and build the result
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        we          = '0;
        waddr       = pos_reg[IW-1:0];
        next_addr   = pos_reg[IW-1:0];
        prev_addr   = pos_reg[IW-1:0];
        wval        = val_reg;
        wnext       = NONE;
        wprev       = NONE;
        wuse        = 1'b0;
        acmd        = '0;
        push_handle = pos_reg[IW-1:0];
        link_load   = 1'b0;
        fin         = 1'b0;
        res_stat    = ST_BAD;
        res_h       = NONE;
        res_val     = '0;
        res_n       = NONE;
        res_p       = NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (is_ins && lk_ok && !full)
                begin
                    // Write the new node in full, then patch neighbors
                    we        = '{val: 1'b1, nxt: 1'b1, prv: 1'b1, used: 1'b1};
                    waddr     = alloc_handle[IW-1:0];
                    next_addr = alloc_handle[IW-1:0];
                    prev_addr = alloc_handle[IW-1:0];
                    wnext     = lk_n;
                    wprev     = lk_p;
                    wuse      = 1'b1;
                    link_load = 1'b1;
                    state_next = S_LINK;
                end
                else if (can_out)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    if (is_ins && lk_ok)
                    begin
                        res_stat = ST_FULL;
                    end
                    else if ((act_reg == ACT_REMOVE) && live)
                    begin
                        // Unlink the node and release its handle
                        res_stat  = ST_OK;
                        res_h     = pos_reg;
                        res_val   = rd_val;
                        res_n     = rd_next;
                        res_p     = rd_prev;
                        we.nxt    = (rd_prev != NONE);
                        next_addr = rd_prev[IW-1:0];
                        wnext     = rd_next;
                        we.prv    = (rd_next != NONE);
                        prev_addr = rd_next[IW-1:0];
                        wprev     = rd_prev;
                        we.used   = 1'b1;
                        wuse      = 1'b0;
                        acmd.push = 1'b1;
                        if (rd_prev == NONE)
                        begin
                            head_next = rd_next;
                        end
                        if (rd_next == NONE)
                        begin
                            tail_next = rd_prev;
                        end
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if ((act_reg == ACT_READ) && live)
                    begin
                        res_stat = ST_OK;
                        res_h    = pos_reg;
                        res_val  = rd_val;
                        res_n    = rd_next;
                        res_p    = rd_prev;
                    end
                end
            end
            S_LINK:
            begin
                if (can_out)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    res_stat   = ST_OK;
                    res_h      = h_reg;
                    res_val    = val_reg;
                    res_n      = n_reg;
                    res_p      = p_reg;
                    we.nxt     = (p_reg != NONE);
                    next_addr  = p_reg[IW-1:0];
                    wnext      = h_reg;
                    we.prv     = (n_reg != NONE);
                    prev_addr  = n_reg[IW-1:0];
                    wprev      = h_reg;
                    acmd.take  = 1'b1;
                    if (p_reg == NONE)
                    begin
                        head_next = h_reg;
                    end
                    if (n_reg == NONE)
                    begin
                        tail_next = h_reg;
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NONE;
            tail_reg   <= NONE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (fin)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action_t'(cmd.action);
            pos_reg <= cmd.position;
            val_reg <= VALUE_BITS'($signed(cmd.value));
        end
        if (link_load)
        begin
            h_reg <= alloc_handle;
            p_reg <= lk_p;
            n_reg <= lk_n;
        end
        if (fin)
        begin
            ostat_reg   <= res_stat;
            ohandle_reg <= res_h;
            ovalue_reg  <= DATA_BITS'($signed(res_val));
            onext_reg   <= res_n;
            oprev_reg   <= res_p;
        end
    end

    // Drive the result channel; list state only moves with a new result
    assign rsp.valid       = ovalid_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.handle      = ohandle_reg;
    assign rsp.read_value  = ovalue_reg;
    assign rsp.next_handle = onext_reg;
    assign rsp.prev_handle = oprev_reg;
    assign rsp.head_handle = head_reg;
    assign rsp.tail_handle = tail_reg;
    assign rsp.length      = count_reg;

    assign list_empty = (count_reg == '0);
    assign out_fail   = ovalid_reg && (ostat_reg != ST_OK);

    `DLL_ASSERT_ALWAYS(a_count_bound, count_reg <= NONE, "node count exceeds pool size")
    `DLL_ASSERT_ALWAYS(a_head_empty, (head_reg == NONE) == list_empty, "head and count disagree")
    `DLL_ASSERT_ALWAYS(a_tail_empty, (tail_reg == NONE) == list_empty, "tail and count disagree")
    `DLL_ASSERT_IMPLY(a_fail_no_handle, out_fail, ohandle_reg == NONE, "failed action has a handle")

endmodule

// ===== sv/dll_node_mem.sv =====
// ---------------------------------------------------------------------------
// dll_node_mem
// Node pool storage: value, successor, predecessor and in-use bit, each a
// synchronous memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dll_node_mem
    import dll_pkg::*;
#(
    parameter int POOL_SIZE  = 64,
    parameter int VALUE_BITS = 32,
    localparam int IW = $clog2(POOL_SIZE),
    localparam int HW = $clog2(POOL_SIZE + 1)
)(
    input  logic                  clk,
    input  logic                  ren,
    input  logic [IW-1:0]         raddr,
    input  node_we_t              we,
    input  logic [IW-1:0]         waddr,
    input  logic [IW-1:0]         next_addr,
    input  logic [IW-1:0]         prev_addr,
    input  logic [VALUE_BITS-1:0] wval,
    input  logic [HW-1:0]         wnext,
    input  logic [HW-1:0]         wprev,
    input  logic                  wuse,
    output logic [VALUE_BITS-1:0] rd_val,
    output logic [HW-1:0]         rd_next,
    output logic [HW-1:0]         rd_prev,
    output logic                  rd_use
);

    logic [VALUE_BITS-1:0] val_mem [POOL_SIZE];
    logic [HW-1:0]         nxt_mem [POOL_SIZE];
    logic [HW-1:0]         prv_mem [POOL_SIZE];
    logic                  use_mem [POOL_SIZE];

    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [HW-1:0]         rd_next_reg;
    logic [HW-1:0]         rd_prev_reg;
    logic                  rd_use_reg;

    // Write each field memory at its own address
    always_ff @(posedge clk)
    begin
        if (we.val)
        begin
            val_mem[waddr] <= wval;
        end
        if (we.used)
        begin
            use_mem[waddr] <= wuse;
        end
        if (we.nxt)
        begin
            nxt_mem[next_addr] <= wnext;
        end
        if (we.prv)
        begin
            prv_mem[prev_addr] <= wprev;
        end
    end

    // Read one node; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rd_val_reg  <= val_mem[raddr];
            rd_next_reg <= nxt_mem[raddr];
            rd_prev_reg <= prv_mem[raddr];
            rd_use_reg  <= use_mem[raddr];
        end
    end

    assign rd_val  = rd_val_reg;
    assign rd_next = rd_next_reg;
    assign rd_prev = rd_prev_reg;
    assign rd_use  = rd_use_reg;

endmodule

// ===== sv/dll_alloc.sv =====
// ---------------------------------------------------------------------------
// dll_alloc
// Node allocator: a stack of released handles in memory, backed by a bump
// pointer over handles never handed out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_top_defines.svh"

module dll_alloc
    import dll_pkg::*;
#(
    parameter int POOL_SIZE = 64,
    localparam int IW = $clog2(POOL_SIZE),
    localparam int HW = $clog2(POOL_SIZE + 1)
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ren,
    input  alloc_cmd_t    cmd,
    input  logic [IW-1:0] push_handle,
    output logic [HW-1:0] alloc_handle,
    output logic [HW-1:0] fresh
);

    localparam logic [HW-1:0] NONE = HW'(POOL_SIZE);

    logic [IW-1:0] stack_mem [POOL_SIZE];
    logic [IW-1:0] stack_rd_reg;
    logic [HW-1:0] free_top_reg;
    logic [HW-1:0] free_top_next;
    logic [HW-1:0] fresh_reg;
    logic [HW-1:0] fresh_next;
    logic [IW-1:0] top_idx;

    assign top_idx = IW'(free_top_reg - 1'b1);

    // Fetch the top of stack on request, push released handles
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            stack_rd_reg <= stack_mem[top_idx];
        end
        if (cmd.push)
        begin
            stack_mem[free_top_reg[IW-1:0]] <= push_handle;
        end
    end

    // Pop from the stack first, bump otherwise
    always_comb
    begin
        free_top_next = free_top_reg;
        fresh_next    = fresh_reg;
        if (cmd.push)
        begin
            free_top_next = free_top_reg + 1'b1;
        end
        else if (cmd.take)
        begin
            if (free_top_reg != '0)
            begin
                free_top_next = free_top_reg - 1'b1;
            end
            else
            begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg <= '0;
            fresh_reg    <= '0;
        end
        else
        begin
            free_top_reg <= free_top_next;
            fresh_reg    <= fresh_next;
        end
    end

    // Bump pointer equals NONE once every handle has been handed out
    assign alloc_handle = (free_top_reg != '0) ? HW'(stack_rd_reg) : fresh_reg;
    assign fresh        = fresh_reg;

    `DLL_ASSERT_ALWAYS(a_top_le_fresh, free_top_reg <= fresh_reg, "free stack deeper than handed-out handles")
    `DLL_ASSERT_IMPLY(a_take_has_room, cmd.take && (free_top_reg == '0), fresh_reg < NONE, "take with no handle left")
    `DLL_ASSERT_IMPLY(a_push_excl_take, cmd.push, !cmd.take, "push and take in one cycle")

endmodule
